### design/cpsat_pkg.sv
// Shared types and codes for the convex polygon overlap unit.
package cpsat_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    // What a queued vertex asks the back end to do.
    typedef enum logic [1:0] {
        CMD_LOAD_A      = 2'd0,
        CMD_LOAD_B      = 2'd1,
        CMD_LOAD_B_TEST = 2'd2
    } cpsat_cmd_kind_t;

endpackage

### design/convex_polygon_sat_overlap_unit.sv
// Top level of the convex polygon overlap unit.
// Vertices of polygon A and then polygon B are pushed one per transfer; the B vertex that
// carries last_point starts the test and yields one result (overlap, status) in the result
// register. A vertex that only loads is taken while the back end is idle, so loads stream
// at one per cycle while no test runs. A test runs from a start state through the edges to a
// finish state on one shared multiplier pair and one read port per vertex store; for two true
// polygons each edge projects all nA+nB vertices, for a point against a polygon each polygon
// edge is tested against the point, and the first separating edge ends the test early. A
// two-entry queue in front holds up to two vertices while a test runs, and one result register
// holds a finished answer until popped; the test cannot finish while it is full and unpopped.
module convex_polygon_sat_overlap_unit
    import cpsat_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         polygon_select,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         empty,
    input  logic                         pop,
    output logic                         overlap,
    output logic [1:0]                   status
);

    logic                         cmd_valid;
    logic                         cmd_pop;
    cpsat_cmd_kind_t              cmd_kind;
    logic signed [COORD_BITS-1:0] cmd_x;
    logic signed [COORD_BITS-1:0] cmd_y;

    // Input queue and classification.
    cpsat_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .polygon_select (polygon_select),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_point     (last_point),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .cmd_kind       (cmd_kind),
        .cmd_x          (cmd_x),
        .cmd_y          (cmd_y)
    );

    // Vertex storage and overlap test.
    cpsat_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_kind  (cmd_kind),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y),
        .empty     (empty),
        .pop       (pop),
        .overlap   (overlap),
        .status    (status)
    );

endmodule

### design/cpsat_front.sv
// Front end: accepts vertices, classifies them and queues them for the back end.
module cpsat_front
    import cpsat_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         polygon_select,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         last_point,
    output logic                         cmd_valid,
    input  logic                         cmd_pop,
    output cpsat_cmd_kind_t              cmd_kind,
    output logic signed [COORD_BITS-1:0] cmd_x,
    output logic signed [COORD_BITS-1:0] cmd_y
);

    cpsat_cmd_kind_t              kind_q [2];
    logic signed [COORD_BITS-1:0] x_q [2];
    logic signed [COORD_BITS-1:0] y_q [2];
    logic                         wr_ptr_reg, wr_ptr_next;
    logic                         rd_ptr_reg, rd_ptr_next;
    logic [1:0]                   count_reg, count_next;
    logic                         push_xfer;
    logic                         pop_xfer;
    cpsat_cmd_kind_t              kind_in;

    // Classify the incoming vertex.
    always_comb
    begin
        if (!polygon_select)
        begin
            kind_in = CMD_LOAD_A;
        end
        else if (last_point)
        begin
            kind_in = CMD_LOAD_B_TEST;
        end
        else
        begin
            kind_in = CMD_LOAD_B;
        end
    end

    // Two-entry queue control.
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign push_xfer = push && !full;
    assign pop_xfer  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push_xfer ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_xfer ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_xfer} - {1'b0, pop_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (push_xfer)
        begin
            kind_q[wr_ptr_reg] <= kind_in;
            x_q[wr_ptr_reg]    <= point_x;
            y_q[wr_ptr_reg]    <= point_y;
        end
    end

    assign cmd_kind = kind_q[rd_ptr_reg];
    assign cmd_x    = x_q[rd_ptr_reg];
    assign cmd_y    = y_q[rd_ptr_reg];

endmodule

### design/cpsat_back.sv
// Back end: vertex stores, edge sequencer, projection datapath and result register.
module cpsat_back
    import cpsat_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_pop,
    input  cpsat_cmd_kind_t              cmd_kind,
    input  logic signed [COORD_BITS-1:0] cmd_x,
    input  logic signed [COORD_BITS-1:0] cmd_y,
    output logic                         empty,
    input  logic                         pop,
    output logic                         overlap,
    output logic [1:0]                   status
);

    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int AXW  = COORD_BITS + 1;
    localparam int MW   = 2 * COORD_BITS + 1;
    localparam int PW   = 2 * COORD_BITS + 2;
    localparam int VW   = 2 * COORD_BITS;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_START  = 12'b0000_0000_0010,
        ST_RD_P   = 12'b0000_0000_0100,
        ST_RD_Q   = 12'b0000_0000_1000,
        ST_AXIS   = 12'b0000_0001_0000,
        ST_DP_MUL = 12'b0000_0010_0000,
        ST_DP_ACC = 12'b0000_0100_0000,
        ST_PRD    = 12'b0000_1000_0000,
        ST_PMUL   = 12'b0001_0000_0000,
        ST_PACC   = 12'b0010_0000_0000,
        ST_GAP    = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } cpsat_state_t;

    cpsat_state_t state_reg, state_next;

    logic [VW-1:0]   mem_a [MAX_POINTS];
    logic [VW-1:0]   mem_b [MAX_POINTS];
    logic [VW-1:0]   rd_a_reg, rd_b_reg;
    logic            rd_sel_reg;
    logic [IDXW-1:0] raddr;
    logic            raddr_b;

    logic [CNTW-1:0] cnt_a_reg, cnt_a_next;
    logic [CNTW-1:0] cnt_b_reg, cnt_b_next;
    logic            ovf_reg, ovf_next;
    logic            sat_reg, sat_next;
    logic            pt_b_reg, pt_b_next;
    logic            e_on_b_reg, e_on_b_next;
    logic [IDXW-1:0] e_k_reg, e_k_next;
    logic            p_on_b_reg, p_on_b_next;
    logic [IDXW-1:0] p_k_reg, p_k_next;

    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [AXW-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic signed [MW-1:0]         prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [PW-1:0]         dp_reg, dp_next;
    logic signed [PW-1:0]         min_a_reg, min_a_next, max_a_reg, max_a_next;
    logic signed [PW-1:0]         min_b_reg, min_b_next, max_b_reg, max_b_next;

    logic            res_valid_reg, res_valid_next;
    logic            res_ov_reg, res_ov_next;
    logic [1:0]      res_st_reg, res_st_next;
    logic            fin_ov_reg, fin_ov_next;
    logic [1:0]      fin_st_reg, fin_st_next;

    logic [VW-1:0]                rdata;
    logic signed [COORD_BITS-1:0] rx, ry;
    logic signed [COORD_BITS-1:0] mul_x, mul_y;
    logic signed [PW-1:0]         dot;
    logic [CNTW-1:0]              n_e, n_p;
    logic [CNTW-1:0]              e_k_plus, p_k_plus;
    logic [IDXW-1:0]              e_next;
    logic                         wr_a, wr_b;
    logic                         result_load;
    logic signed [PW-1:0]         pt_val;
    logic                         gap;

    // Vertex stores with registered read.
    assign wr_a = cmd_pop && (cmd_kind == CMD_LOAD_A) && (cnt_a_reg < CNTW'(MAX_POINTS));
    assign wr_b = cmd_pop && (cmd_kind != CMD_LOAD_A) && (cnt_b_reg < CNTW'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[IDXW-1:0]] <= {cmd_y, cmd_x};
        end
        if (wr_b)
        begin
            mem_b[cnt_b_reg[IDXW-1:0]] <= {cmd_y, cmd_x};
        end
        rd_a_reg   <= mem_a[raddr];
        rd_b_reg   <= mem_b[raddr];
        rd_sel_reg <= raddr_b;
    end

    assign rdata = rd_sel_reg ? rd_b_reg : rd_a_reg;
    assign rx    = rdata[COORD_BITS-1:0];
    assign ry    = rdata[VW-1:COORD_BITS];

    // Edge and projection index arithmetic.
    assign n_e      = e_on_b_reg ? cnt_b_reg : cnt_a_reg;
    assign n_p      = p_on_b_reg ? cnt_b_reg : cnt_a_reg;
    assign e_k_plus = CNTW'(e_k_reg) + CNTW'(1);
    assign p_k_plus = CNTW'(p_k_reg) + CNTW'(1);
    assign e_next   = (e_k_plus == n_e) ? '0 : e_k_plus[IDXW-1:0];

    // Read address selection.
    always_comb
    begin
        raddr   = e_k_reg;
        raddr_b = e_on_b_reg;
        if (state_reg == ST_RD_Q)
        begin
            raddr = e_next;
        end
        else if (state_reg == ST_PRD)
        begin
            raddr   = p_k_reg;
            raddr_b = p_on_b_reg;
        end
    end

    // Shared multiplier pair and the dot product sum.
    assign mul_x = (state_reg == ST_DP_MUL) ? px_reg : rx;
    assign mul_y = (state_reg == ST_DP_MUL) ? py_reg : ry;
    assign dot   = PW'(prod_x_reg) + PW'(prod_y_reg);

    // Interval test for the current axis.
    assign pt_val = pt_b_reg ? min_b_reg : min_a_reg;
    always_comb
    begin
        if (!sat_reg)
        begin
            gap = (pt_val > dp_reg);
        end
        else if (min_a_reg < min_b_reg)
        begin
            gap = (min_b_reg > max_a_reg);
        end
        else
        begin
            gap = (min_a_reg > max_b_reg);
        end
    end

    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid;
    assign result_load = (state_reg == ST_DONE) && (!res_valid_reg || pop);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        sat_next       = sat_reg;
        pt_b_next      = pt_b_reg;
        e_on_b_next    = e_on_b_reg;
        e_k_next       = e_k_reg;
        p_on_b_next    = p_on_b_reg;
        p_k_next       = p_k_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        prod_x_next    = prod_x_reg;
        prod_y_next    = prod_y_reg;
        dp_next        = dp_reg;
        min_a_next     = min_a_reg;
        max_a_next     = max_a_reg;
        min_b_next     = min_b_reg;
        max_b_next     = max_b_reg;
        res_valid_next = res_valid_reg;
        res_ov_next    = res_ov_reg;
        res_st_next    = res_st_reg;
        fin_ov_next    = fin_ov_reg;
        fin_st_next    = fin_st_reg;

        if (res_valid_reg && pop)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_kind == CMD_LOAD_A)
                    begin
                        if (wr_a)
                        begin
                            cnt_a_next = cnt_a_reg + CNTW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (wr_b)
                        begin
                            cnt_b_next = cnt_b_reg + CNTW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (cmd_kind == CMD_LOAD_B_TEST)
                        begin
                            state_next = ST_START;
                        end
                    end
                end
            end

            ST_START:
            begin
                fin_ov_next = 1'b0;
                fin_st_next = STATUS_OK;
                e_k_next    = '0;
                e_on_b_next = 1'b0;
                sat_next    = 1'b1;
                pt_b_next   = 1'b0;
                if (ovf_reg)
                begin
                    fin_st_next = STATUS_OVERFLOW;
                    state_next  = ST_DONE;
                end
                else if (cnt_a_reg == '0 || cnt_b_reg == '0)
                begin
                    fin_st_next = STATUS_EMPTY;
                    state_next  = ST_DONE;
                end
                else if (cnt_a_reg == CNTW'(1) && cnt_b_reg == CNTW'(1))
                begin
                    state_next = ST_DONE;
                end
                else if (cnt_a_reg == CNTW'(1))
                begin
                    sat_next    = 1'b0;
                    e_on_b_next = 1'b1;
                    state_next  = ST_RD_P;
                end
                else if (cnt_b_reg == CNTW'(1))
                begin
                    sat_next   = 1'b0;
                    pt_b_next  = 1'b1;
                    state_next = ST_RD_P;
                end
                else
                begin
                    state_next = ST_RD_P;
                end
            end

            ST_RD_P:
            begin
                state_next = ST_RD_Q;
            end

            ST_RD_Q:
            begin
                px_next    = rx;
                py_next    = ry;
                state_next = ST_AXIS;
            end

            ST_AXIS:
            begin
                // Edge normal: (p.y - q.y, q.x - p.x).
                ax_next     = AXW'(py_reg) - AXW'(ry);
                ay_next     = AXW'(rx) - AXW'(px_reg);
                p_on_b_next = pt_b_reg;
                p_k_next    = '0;
                state_next  = sat_reg ? ST_PRD : ST_DP_MUL;
            end

            ST_DP_MUL:
            begin
                prod_x_next = MW'(ax_reg) * MW'(mul_x);
                prod_y_next = MW'(ay_reg) * MW'(mul_y);
                state_next  = ST_DP_ACC;
            end

            ST_DP_ACC:
            begin
                dp_next    = dot;
                state_next = ST_PRD;
            end

            ST_PRD:
            begin
                state_next = ST_PMUL;
            end

            ST_PMUL:
            begin
                prod_x_next = MW'(ax_reg) * MW'(mul_x);
                prod_y_next = MW'(ay_reg) * MW'(mul_y);
                state_next  = ST_PACC;
            end

            ST_PACC:
            begin
                // Fold this vertex into its polygon's interval.
                if (p_on_b_reg)
                begin
                    if (p_k_reg == '0 || dot < min_b_reg)
                    begin
                        min_b_next = dot;
                    end
                    if (p_k_reg == '0 || dot > max_b_reg)
                    begin
                        max_b_next = dot;
                    end
                end
                else
                begin
                    if (p_k_reg == '0 || dot < min_a_reg)
                    begin
                        min_a_next = dot;
                    end
                    if (p_k_reg == '0 || dot > max_a_reg)
                    begin
                        max_a_next = dot;
                    end
                end
                if (p_k_plus == n_p)
                begin
                    if (!p_on_b_reg && sat_reg)
                    begin
                        p_on_b_next = 1'b1;
                        p_k_next    = '0;
                        state_next  = ST_PRD;
                    end
                    else
                    begin
                        state_next = ST_GAP;
                    end
                end
                else
                begin
                    p_k_next   = p_k_plus[IDXW-1:0];
                    state_next = ST_PRD;
                end
            end

            ST_GAP:
            begin
                if (gap)
                begin
                    fin_ov_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else if (e_k_plus == n_e)
                begin
                    if (!e_on_b_reg && sat_reg)
                    begin
                        e_on_b_next = 1'b1;
                        e_k_next    = '0;
                        state_next  = ST_RD_P;
                    end
                    else
                    begin
                        fin_ov_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
                else
                begin
                    e_k_next   = e_k_plus[IDXW-1:0];
                    state_next = ST_RD_P;
                end
            end

            ST_DONE:
            begin
                if (result_load)
                begin
                    res_valid_next = 1'b1;
                    res_ov_next    = fin_ov_reg;
                    res_st_next    = fin_st_reg;
                    cnt_a_next     = '0;
                    cnt_b_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sat_reg    <= sat_next;
        pt_b_reg   <= pt_b_next;
        e_on_b_reg <= e_on_b_next;
        e_k_reg    <= e_k_next;
        p_on_b_reg <= p_on_b_next;
        p_k_reg    <= p_k_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        dp_reg     <= dp_next;
        min_a_reg  <= min_a_next;
        max_a_reg  <= max_a_next;
        min_b_reg  <= min_b_next;
        max_b_reg  <= max_b_next;
        res_ov_reg <= res_ov_next;
        res_st_reg <= res_st_next;
        fin_ov_reg <= fin_ov_next;
        fin_st_reg <= fin_st_next;
    end

    assign empty   = !res_valid_reg;
    assign overlap = res_ov_reg;
    assign status  = res_st_reg;

    // The fill counts never pass the store depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CNTW'(MAX_POINTS)) && (cnt_b_reg <= CNTW'(MAX_POINTS)))
        else $error("vertex count exceeds store depth");

    // Delivering a result clears both polygons and the overflow flag.
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (cnt_a_reg == '0) && (cnt_b_reg == '0) && !ovf_reg)
        else $error("state not cleared after a result");

    // An overflowed test never reaches the interval compare.
    a_no_arith_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAP) |-> !ovf_reg)
        else $error("geometry test ran with overflow pending");

    // A queued command is taken only while the back end is idle.
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_IDLE) || (state_reg == ST_START))
        else $error("command taken outside idle");

endmodule
